>>> src/tpe_pkg.sv
// Package for the triangle plane equation block.
// Widths, fixed point constants and the structs passed between stages.
// No dependencies.
package tpe_pkg;

  localparam int COORD_W   = 16;
  localparam int COORD_FRAC_BITS = 8;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int SC_W      = 30;
  localparam int SQ_W      = 2 * SC_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int Q_W       = 15;
  localparam int NUM_W     = SC_W + Q_W + 1;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int NRM_W     = 16;
  localparam int DOT_W     = NRM_W + COORD_W;
  localparam int DSUM_W    = DOT_W + 2;
  localparam int DSHIFT    = 6 + COORD_FRAC_BITS;
  localparam int DIST_W    = 24;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  // what rides along beside the arithmetic
  typedef struct packed {
    vtx_t       a;
    logic [2:0] neg;
    logic       degen;
  } side_t;

  typedef struct packed {
    side_t                s;
    logic [2:0][SC_W-1:0] sc;
  } sq_side_t;

endpackage

>>> src/tpe_front.sv
// Front end: edge vectors, cross product, magnitude scaling, sum of squares.
// Five register stages. Depends on tpe_pkg.
module tpe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  tpe_pkg::vtx_t              va,
  input  tpe_pkg::vtx_t              vb,
  input  tpe_pkg::vtx_t              vc,
  output logic                       out_valid,
  output logic [tpe_pkg::SUM_W-1:0]  out_sum,
  output tpe_pkg::sq_side_t          out_side
);
  import tpe_pkg::*;

  logic [3:0] vld;

  // stage 1: edges
  logic signed [DIFF_W-1:0] ud [3];
  logic signed [DIFF_W-1:0] vd [3];
  logic signed [DIFF_W-1:0] u1 [3];
  logic signed [DIFF_W-1:0] v1 [3];
  vtx_t a1, a2, a3;

  // stage 2: products
  logic signed [PROD_W-1:0] p2 [6];

  // stage 3: scaled magnitudes
  logic signed [CROSS_W-1:0] cr [3];
  logic [CROSS_W-1:0]        mfull [3];
  logic [MAG_W-1:0]          m [3];
  logic [MAG_W-1:0]          all_bits;
  logic [2:0]                sh;
  logic [2:0][SC_W-1:0]      sc3, sc4;
  logic [2:0]                neg3, neg4;
  logic                      degen3, degen4;

  // stage 4: squares
  logic [SQ_W-1:0] sq4 [3];
  sq_side_t        side4;

  always_comb begin
    ud[0] = DIFF_W'(vb.x) - DIFF_W'(va.x);
    ud[1] = DIFF_W'(vb.y) - DIFF_W'(va.y);
    ud[2] = DIFF_W'(vb.z) - DIFF_W'(va.z);
    vd[0] = DIFF_W'(vc.x) - DIFF_W'(va.x);
    vd[1] = DIFF_W'(vc.y) - DIFF_W'(va.y);
    vd[2] = DIFF_W'(vc.z) - DIFF_W'(va.z);
  end

  always_comb begin
    cr[0] = CROSS_W'(p2[0]) - CROSS_W'(p2[1]);
    cr[1] = CROSS_W'(p2[2]) - CROSS_W'(p2[3]);
    cr[2] = CROSS_W'(p2[4]) - CROSS_W'(p2[5]);
    for (int i = 0; i < 3; i++) begin
      mfull[i] = cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
      m[i]     = mfull[i][MAG_W-1:0];
    end
    all_bits = m[0] | m[1] | m[2];
    // smallest shift that brings every magnitude under 2^30
    if (all_bits[33]) begin
      sh = 3'd4;
    end else if (all_bits[32]) begin
      sh = 3'd3;
    end else if (all_bits[31]) begin
      sh = 3'd2;
    end else if (all_bits[30]) begin
      sh = 3'd1;
    end else begin
      sh = 3'd0;
    end
    for (int i = 0; i < 3; i++) begin
      sc3[i]  = SC_W'(m[i] >> sh);
      neg3[i] = cr[i][CROSS_W-1];
    end
    degen3 = (all_bits == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[2:0], in_valid};
      out_valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= ud;
      v1 <= vd;
      a1 <= va;

      p2[0] <= u1[1] * v1[2];
      p2[1] <= u1[2] * v1[1];
      p2[2] <= u1[2] * v1[0];
      p2[3] <= u1[0] * v1[2];
      p2[4] <= u1[0] * v1[1];
      p2[5] <= u1[1] * v1[0];
      a2    <= a1;

      sc4    <= sc3;
      neg4   <= neg3;
      degen4 <= degen3;
      a3     <= a2;

      for (int i = 0; i < 3; i++) begin
        sq4[i] <= sc4[i] * sc4[i];
      end
      side4.sc      <= sc4;
      side4.s.neg   <= neg4;
      side4.s.degen <= degen4;
      side4.s.a     <= a3;

      out_side <= side4;
      out_sum  <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    end
  end

endmodule

>>> src/tpe_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the side data alongside. Depends on tpe_pkg.
module tpe_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tpe_pkg::SUM_W-1:0]   in_sum,
  input  tpe_pkg::sq_side_t           in_side,
  output logic                        out_valid,
  output logic [tpe_pkg::ROOT_W-1:0]  out_root,
  output tpe_pkg::sq_side_t           out_side
);
  import tpe_pkg::*;

  logic [SUM_W-1:0] rem_a  [SQRT_STEPS+1];
  logic [SUM_W-1:0] root_a [SQRT_STEPS+1];
  logic             vld_a  [SQRT_STEPS+1];
  sq_side_t         side_a [SQRT_STEPS+1];

  assign rem_a[0]  = in_sum;
  assign root_a[0] = '0;
  assign vld_a[0]  = in_valid;
  assign side_a[0] = in_side;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int BITPOS = 2 * (SQRT_STEPS - 1 - k);
    logic [SUM_W-1:0] bit_val;
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] rem_next;
    logic [SUM_W-1:0] root_next;
    logic [SUM_W-1:0] rem_q;
    logic [SUM_W-1:0] root_q;
    logic             vld_q;
    sq_side_t         side_q;

    always_comb begin
      bit_val = SUM_W'(1) << BITPOS;
      trial   = root_a[k] + bit_val;
      if (rem_a[k] >= trial) begin
        rem_next  = rem_a[k] - trial;
        root_next = (root_a[k] >> 1) + bit_val;
      end else begin
        rem_next  = rem_a[k];
        root_next = root_a[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q  <= rem_next;
        root_q <= root_next;
        side_q <= side_a[k];
      end
    end

    assign rem_a[k+1]  = rem_q;
    assign root_a[k+1] = root_q;
    assign vld_a[k+1]  = vld_q;
    assign side_a[k+1] = side_q;
  end

  logic unused_rem;
  assign unused_rem = ^rem_a[SQRT_STEPS] ^ ^root_a[SQRT_STEPS][SUM_W-1:ROOT_W];

  assign out_valid = vld_a[SQRT_STEPS];
  assign out_root  = root_a[SQRT_STEPS][ROOT_W-1:0];
  assign out_side  = side_a[SQRT_STEPS];

endmodule

>>> src/tpe_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Forms (sc*2^15 + L) / (2L) for each normal component. Depends on tpe_pkg.
module tpe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tpe_pkg::ROOT_W-1:0]  in_root,
  input  tpe_pkg::sq_side_t           in_side,
  output logic                        out_valid,
  output logic [2:0][tpe_pkg::Q_W-1:0] out_q,
  output tpe_pkg::side_t              out_side
);
  import tpe_pkg::*;

  logic [2:0][NUM_W-1:0] rem_a [Q_W+1];
  logic [2:0][Q_W-1:0]   q_a   [Q_W+1];
  logic [DEN_W-1:0]      den_a [Q_W+1];
  logic                  vld_a [Q_W+1];
  side_t                 side_a [Q_W+1];

  for (genvar i = 0; i < 3; i++) begin : g_num
    assign rem_a[0][i] = {1'b0, in_side.sc[i], Q_W'(0)} + NUM_W'(in_root);
  end
  assign q_a[0]    = '0;
  assign den_a[0]  = {in_root, 1'b0};
  assign vld_a[0]  = in_valid;
  assign side_a[0] = in_side.s;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int J = Q_W - 1 - k;
    logic [NUM_W-1:0]      dsh;
    logic [2:0][NUM_W-1:0] rem_next;
    logic [2:0][Q_W-1:0]   q_next;
    logic [2:0][NUM_W-1:0] rem_q;
    logic [2:0][Q_W-1:0]   q_q;
    logic [DEN_W-1:0]      den_q;
    logic                  vld_q;
    side_t                 side_q;

    always_comb begin
      dsh = NUM_W'(den_a[k]) << J;
      for (int i = 0; i < 3; i++) begin
        rem_next[i] = rem_a[k][i];
        q_next[i]   = q_a[k][i];
        if (rem_a[k][i] >= dsh) begin
          rem_next[i]  = rem_a[k][i] - dsh;
          q_next[i][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q  <= rem_next;
        q_q    <= q_next;
        den_q  <= den_a[k];
        side_q <= side_a[k];
      end
    end

    assign rem_a[k+1]  = rem_q;
    assign q_a[k+1]    = q_q;
    assign den_a[k+1]  = den_q;
    assign vld_a[k+1]  = vld_q;
    assign side_a[k+1] = side_q;
  end

  logic unused_tail;
  assign unused_tail = ^rem_a[Q_W] ^ ^den_a[Q_W];

  assign out_valid = vld_a[Q_W];
  assign out_q     = q_a[Q_W];
  assign out_side  = side_a[Q_W];

endmodule

>>> src/triangle_plane_equation.sv
// Triangle plane equation: unit normal (Q1.14) and distance (Q15.8) per triangle.
// Top level: front end, square root, divider, dot product and output register.
// Depends on tpe_pkg, tpe_front, tpe_sqrt, tpe_div.
//
// Input channel: in_valid / in_stall with the nine vertex coordinates
// (A, B, C in signed Q8.8). Output channel: out_valid / out_stall with
// nx, ny, nz, plane_dist and degenerate.
// One triangle per cycle sustained while the pipeline is not held. An
// accepted input beat passes the front end (cross product and sum of
// squares), 31 square-root stages (one root bit each), 15 divider stages
// (one quotient bit each), then a multiply stage and the output register.
// The whole pipeline advances together; it holds only while a result sits
// in the output register and out_stall is high, and in_stall is raised in
// exactly those cycles, so no beat is lost or repeated.
// A degenerate triangle (zero cross product) gives a zero normal, zero
// distance and degenerate set.
// Reset clears all valid bits; nothing else needs initializing.
module triangle_plane_equation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tpe_pkg::coord_t                  ax,
  input  tpe_pkg::coord_t                  ay,
  input  tpe_pkg::coord_t                  az,
  input  tpe_pkg::coord_t                  bx,
  input  tpe_pkg::coord_t                  by_coord,
  input  tpe_pkg::coord_t                  bz,
  input  tpe_pkg::coord_t                  cx,
  input  tpe_pkg::coord_t                  cy,
  input  tpe_pkg::coord_t                  cz,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tpe_pkg::NRM_W-1:0] nx,
  output logic signed [tpe_pkg::NRM_W-1:0] ny,
  output logic signed [tpe_pkg::NRM_W-1:0] nz,
  output logic signed [tpe_pkg::DIST_W-1:0] plane_dist,
  output logic                             degenerate
);
  import tpe_pkg::*;

  localparam logic [DSUM_W:0] RND     = (DSUM_W+1)'(1) << (DSHIFT - 1);
  localparam logic [DSUM_W:0] POS_MAX = (DSUM_W+1)'(8388607);
  localparam logic [DSUM_W:0] NEG_MAX = (DSUM_W+1)'(8388608);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  vtx_t va, vb, vc;
  assign va = '{x: ax, y: ay, z: az};
  assign vb = '{x: bx, y: by_coord, z: bz};
  assign vc = '{x: cx, y: cy, z: cz};

  logic              f_valid;
  logic [SUM_W-1:0]  f_sum;
  sq_side_t          f_side;

  tpe_front u_front (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .va, .vb, .vc,
    .out_valid (f_valid),
    .out_sum   (f_sum),
    .out_side  (f_side)
  );

  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  sq_side_t          s_side;

  tpe_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_sum    (f_sum),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  logic                d_valid;
  logic [2:0][Q_W-1:0] d_q;
  side_t               d_side;

  tpe_div u_div (
    .clk, .rst, .en,
    .in_valid  (s_valid),
    .in_root   (s_root),
    .in_side   (s_side),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_side  (d_side)
  );

  // signed normal and its products with vertex A
  logic signed [NRM_W-1:0] n_next [3];
  logic signed [NRM_W-1:0] n_q    [3];
  logic signed [DOT_W-1:0] prod_q [3];
  logic                    m_valid;
  logic                    m_degen;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_next[i] = d_side.neg[i] ? -NRM_W'(d_q[i]) : NRM_W'(d_q[i]);
    end
  end

  // distance: round magnitude, ties away from zero, then saturate
  logic signed [DSUM_W-1:0] dsum;
  logic [DSUM_W:0]          dmag;
  logic [DSUM_W:0]          r;
  logic signed [DIST_W-1:0] dist_next;

  always_comb begin
    dsum = DSUM_W'(prod_q[0]) + DSUM_W'(prod_q[1]) + DSUM_W'(prod_q[2]);
    dmag = dsum[DSUM_W-1] ? (DSUM_W+1)'(-dsum) : (DSUM_W+1)'(dsum);
    r    = (dmag + RND) >> DSHIFT;
    if (dsum[DSUM_W-1]) begin
      dist_next = (r > NEG_MAX) ? DIST_W'(-8388608) : -DIST_W'(r);
    end else begin
      dist_next = (r > POS_MAX) ? DIST_W'(8388607) : DIST_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= d_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q       <= n_next;
      prod_q[0] <= n_next[0] * d_side.a.x;
      prod_q[1] <= n_next[1] * d_side.a.y;
      prod_q[2] <= n_next[2] * d_side.a.z;
      m_degen   <= d_side.degen;

      nx         <= m_degen ? '0 : n_q[0];
      ny         <= m_degen ? '0 : n_q[1];
      nz         <= m_degen ? '0 : n_q[2];
      plane_dist <= m_degen ? '0 : dist_next;
      degenerate <= m_degen;
    end
  end

endmodule
